>>> design/ole_pkg.sv
// ----------------------------------------------------------------------------
// ole_pkg
// Shared types and codes for the ordered list engine: commands, status
// codes, the per-cell operation and the controller states.
// ----------------------------------------------------------------------------
package ole_pkg;

    typedef enum logic [3:0] {
        CMD_APPEND     = 4'd0,
        CMD_REMOVE_AT  = 4'd1,
        CMD_REMOVE_VAL = 4'd2,
        CMD_CLEAR      = 4'd3,
        CMD_GET        = 4'd4,
        CMD_FIRST      = 4'd5,
        CMD_LAST       = 4'd6,
        CMD_REPLACE    = 4'd7,
        CMD_CONTAINS   = 4'd8
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_EMPTY     = 3'd1,
        STAT_RANGE     = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_FULL      = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_SHIFT
    } cell_op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_EXEC
    } state_t;

endpackage

>>> design/ole_cell.sv
// ----------------------------------------------------------------------------
// ole_cell
// One list slot. Holds a word, compares it against the broadcast key or
// position, and on a removal takes the word of its upper neighbor.
// ----------------------------------------------------------------------------
module ole_cell #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32,
    parameter int IDX        = 0
) (
    input  logic                         clk,
    input  ole_pkg::cell_op_t            op,
    input  logic [$clog2(DEPTH)-1:0]     op_idx,
    input  logic [DATA_WIDTH-1:0]        wdata,
    input  logic [DATA_WIDTH-1:0]        shift_in,
    input  logic [DATA_WIDTH-1:0]        key,
    input  logic [6:0]                   pos,
    input  logic [$clog2(DEPTH+1)-1:0]   count,
    input  logic                         sel_pos,
    output logic [DATA_WIDTH-1:0]        data,
    output logic                         hit
);
    import ole_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = (CW > 7) ? CW : 7;

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  live;

    assign live = CW'(IDX) < count;
    // position compare is 1-based
    assign hit  = live && (sel_pos ? (KW'(IDX + 1) == KW'(pos)) : (data_reg == key));
    assign data = data_reg;

    always_comb
    begin
        data_next = data_reg;
        case (op)
            CELL_WRITE:
            begin
                if (op_idx == PW'(IDX))
                    data_next = wdata;
            end
            CELL_SHIFT:
            begin
                if (PW'(IDX) >= op_idx)
                    data_next = shift_in;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

>>> design/ole_find_tree.sv
// ----------------------------------------------------------------------------
// ole_find_tree
// Registered reduction tree over the cell hit flags, one register per level;
// the root gives the first hit with its word and the last hit position.
// ----------------------------------------------------------------------------
module ole_find_tree #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                       clk,
    input  logic [DEPTH-1:0]           hit,
    input  logic [DATA_WIDTH-1:0]      data_in [DEPTH],
    output logic                       any_hit,
    output logic [$clog2(DEPTH)-1:0]   first_idx,
    output logic [DATA_WIDTH-1:0]      first_data,
    output logic [$clog2(DEPTH)-1:0]   last_idx
);
    localparam int PW    = $clog2(DEPTH);
    localparam int N     = 1 << PW;
    localparam int NODES = 2 * N - 1;

    // heap order: node n has children 2n+1 (lower positions) and 2n+2
    logic                  any_reg  [NODES];
    logic [PW-1:0]         fidx_reg [NODES];
    logic [PW-1:0]         lidx_reg [NODES];
    logic [DATA_WIDTH-1:0] data_reg [NODES];

    always_ff @(posedge clk)
    begin
        for (int n = 0; n < N - 1; n++)
        begin
            any_reg[n] <= any_reg[2*n+1] | any_reg[2*n+2];
            if (any_reg[2*n+1])
            begin
                fidx_reg[n] <= fidx_reg[2*n+1];
                data_reg[n] <= data_reg[2*n+1];
            end
            else
            begin
                fidx_reg[n] <= fidx_reg[2*n+2];
                data_reg[n] <= data_reg[2*n+2];
            end
            lidx_reg[n] <= any_reg[2*n+2] ? lidx_reg[2*n+2] : lidx_reg[2*n+1];
        end
        for (int j = 0; j < N; j++)
        begin
            if (j < DEPTH)
            begin
                any_reg[N-1+j]  <= hit[j];
                data_reg[N-1+j] <= data_in[j];
            end
            else
            begin
                any_reg[N-1+j]  <= 1'b0;
                data_reg[N-1+j] <= '0;
            end
            fidx_reg[N-1+j] <= PW'(j);
            lidx_reg[N-1+j] <= PW'(j);
        end
    end

    assign any_hit    = any_reg[0];
    assign first_idx  = fidx_reg[0];
    assign first_data = data_reg[0];
    assign last_idx   = lidx_reg[0];

endmodule

>>> design/ordered_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_list_engine
// Ordered list of up to DEPTH signed words, one command word in, one result
// word out, on valid/ready channels.
//
// Usage: present cmd/position/value with in_valid; the word is taken when
// in_ready is high. The list lives in a row of DEPTH cells, each comparing
// its word against the key in parallel and shifting down on a removal.
// Hits go through a registered tree of log2(DEPTH) levels.
// One command is in flight at a time: a new command is taken only once the
// last one has passed its search and execute steps, so the command rate is
// set by the depth of the search tree.
// A finished result sits in the output register; the next command is taken
// while it waits. If the receiver stalls, the following command holds in
// its last step until the output register frees up.
// Reset: the list is empty (count zero), no result pending. Cell contents
// are not cleared; only slots below the count are ever read.
// ----------------------------------------------------------------------------
module ordered_list_engine #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [3:0]         cmd,
    input  logic [6:0]         position,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic signed [31:0] item_value,
    output logic [6:0]         found_position,
    output logic               found,
    output logic [6:0]         entry_count,
    output logic               is_empty
);
    import ole_pkg::*;

    localparam int PW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int KW  = (CW > 7) ? CW : 7;
    localparam int FW  = (PW + 1 > 7) ? PW + 1 : 7;
    localparam int TW  = $clog2(PW + 1);

    state_t                state_reg, state_next;
    logic [TW-1:0]         tcnt_reg, tcnt_next;
    logic [3:0]            cmd_reg;
    logic [6:0]            pos_reg;
    logic [DATA_WIDTH-1:0] key_reg, key_next;
    logic [CW-1:0]         count_reg, count_next;

    logic                  out_valid_reg;
    logic [2:0]            status_reg, status_next;
    logic [31:0]           item_reg, item_next;
    logic [6:0]            fpos_reg, fpos_next;
    logic                  found_reg, found_next;

    logic                  accept;
    logic                  exec_go;
    logic                  sel_pos;
    cell_op_t              cell_op;
    logic [PW-1:0]         cell_idx;

    logic [DEPTH-1:0]      hit;
    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic                  any_hit;
    logic [PW-1:0]         first_idx;
    logic [PW-1:0]         last_idx;
    logic [DATA_WIDTH-1:0] first_data;
    logic [31:0]           first_word;

    logic                  empty_now;
    logic                  full_now;
    logic                  pos_ok;
    logic [FW-1:0]         first_pos;
    logic [FW-1:0]         last_pos;
    logic [FW-1:0]         app_pos;
    logic [KW-1:0]         count_ext;

    // width conversions between the 32-bit ports and the stored words
    generate
        if (DATA_WIDTH <= 32)
        begin : g_narrow
            assign key_next = value[DATA_WIDTH-1:0];
        end
        else
        begin : g_wide
            assign key_next = {{(DATA_WIDTH-32){value[31]}}, value};
        end
        if (DATA_WIDTH >= 32)
        begin : g_out_trunc
            assign first_word = first_data[31:0];
        end
        else
        begin : g_out_sext
            assign first_word = {{(32-DATA_WIDTH){first_data[DATA_WIDTH-1]}}, first_data};
        end
    endgenerate

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign exec_go  = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);
    assign sel_pos  = cmd_reg inside {CMD_REMOVE_AT, CMD_GET, CMD_REPLACE};

    // cell row
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] nbr;
            if (gi == DEPTH - 1)
            begin : g_last
                assign nbr = cell_data[gi];
            end
            else
            begin : g_mid
                assign nbr = cell_data[gi+1];
            end
            ole_cell #(
                .DEPTH      (DEPTH),
                .DATA_WIDTH (DATA_WIDTH),
                .IDX        (gi)
            ) u_cell (
                .clk      (clk),
                .op       (cell_op),
                .op_idx   (cell_idx),
                .wdata    (key_reg),
                .shift_in (nbr),
                .key      (key_reg),
                .pos      (pos_reg),
                .count    (count_reg),
                .sel_pos  (sel_pos),
                .data     (cell_data[gi]),
                .hit      (hit[gi])
            );
        end
    endgenerate

    ole_find_tree #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_tree (
        .clk        (clk),
        .hit        (hit),
        .data_in    (cell_data),
        .any_hit    (any_hit),
        .first_idx  (first_idx),
        .first_data (first_data),
        .last_idx   (last_idx)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        tcnt_next  = tcnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                tcnt_next = '0;
                if (accept)
                    state_next = S_SEARCH;
            end
            S_SEARCH:
            begin
                // leaves plus one register per tree level
                if (tcnt_reg == TW'(PW))
                    state_next = S_EXEC;
                else
                    tcnt_next = tcnt_reg + TW'(1);
            end
            S_EXEC:
            begin
                if (exec_go)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // command decode and results
    assign count_ext = KW'(count_reg);
    assign empty_now = (count_reg == '0);
    assign full_now  = (count_reg == CW'(DEPTH));
    assign pos_ok    = (pos_reg != 7'd0) && (KW'(pos_reg) <= count_ext);
    assign first_pos = FW'(first_idx) + FW'(1);
    assign last_pos  = FW'(last_idx) + FW'(1);
    assign app_pos   = FW'(count_reg) + FW'(1);

    always_comb
    begin
        status_next = STAT_OK;
        item_next   = '0;
        fpos_next   = '0;
        found_next  = 1'b0;
        count_next  = count_reg;
        cell_op     = CELL_HOLD;
        cell_idx    = first_idx;
        case (cmd_reg)
            CMD_APPEND:
            begin
                if (full_now)
                    status_next = STAT_FULL;
                else
                begin
                    cell_op    = CELL_WRITE;
                    cell_idx   = count_reg[PW-1:0];
                    count_next = count_reg + CW'(1);
                    fpos_next  = app_pos[6:0];
                end
            end
            CMD_REMOVE_AT, CMD_REMOVE_VAL:
            begin
                if (empty_now)
                    status_next = STAT_EMPTY;
                else if (cmd_reg == CMD_REMOVE_AT && !pos_ok)
                    status_next = STAT_RANGE;
                else if (!any_hit)
                    status_next = STAT_NOT_FOUND;
                else
                begin
                    cell_op    = CELL_SHIFT;
                    item_next  = first_word;
                    fpos_next  = first_pos[6:0];
                    found_next = (cmd_reg == CMD_REMOVE_VAL);
                    count_next = count_reg - CW'(1);
                end
            end
            CMD_CLEAR:
            begin
                count_next = '0;
            end
            CMD_GET, CMD_REPLACE:
            begin
                if (empty_now)
                    status_next = STAT_EMPTY;
                else if (!pos_ok)
                    status_next = STAT_RANGE;
                else
                begin
                    fpos_next = pos_reg;
                    if (cmd_reg == CMD_GET)
                        item_next = first_word;
                    else
                        cell_op = CELL_WRITE;
                end
            end
            CMD_FIRST, CMD_LAST, CMD_CONTAINS:
            begin
                if (empty_now)
                    status_next = STAT_EMPTY;
                else if (!any_hit)
                    status_next = STAT_NOT_FOUND;
                else
                begin
                    found_next = 1'b1;
                    fpos_next  = (cmd_reg == CMD_LAST) ? last_pos[6:0] : first_pos[6:0];
                end
            end
            default:
            begin
                status_next = STAT_OK;
            end
        endcase
        if (!exec_go)
        begin
            cell_op    = CELL_HOLD;
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tcnt_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tcnt_reg  <= tcnt_next;
            count_reg <= count_next;
            if (exec_go)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
            pos_reg <= position;
            key_reg <= key_next;
        end
        if (exec_go)
        begin
            status_reg <= status_next;
            item_reg   <= item_next;
            fpos_reg   <= fpos_next;
            found_reg  <= found_next;
        end
    end

    // count is only touched on exec_go, so it already matches the held word
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign item_value     = item_reg;
    assign found_position = fpos_reg;
    assign found          = found_reg;
    assign entry_count    = count_ext[6:0];
    assign is_empty       = empty_now;

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb - ordered_list_engine testbench
// Drives command words on the input channel and checks every result word
// against an in-bench list predictor. A short directed pass covers the empty
// list, value extremes, bad positions and searches. It is followed by filling
// to capacity and by random command streams under three idling patterns.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ole_pkg::*;

    localparam int          LIST_DEPTH     = 64;
    localparam logic [3:0]  CMD_UNUSED_MAX = 4'd15;
    localparam int          MAX_REPORTS    = 50;

    typedef struct {
        status_t     status;
        logic [31:0] item_value;
        logic [6:0]  found_position;
        logic        found;
        logic [6:0]  entry_count;
        logic        is_empty;
    } list_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [3:0]         cmd = '0;
    logic [6:0]         position = '0;
    logic signed [31:0] value = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [2:0]         status;
    logic signed [31:0] item_value;
    logic [6:0]         found_position;
    logic               found;
    logic [6:0]         entry_count;
    logic               is_empty;

    // predictor state
    logic [31:0]  list_words [LIST_DEPTH];
    int           list_count = 0;
    int           peak_count = 0;

    list_result_t pending_results [$];
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           n_sent = 0;
    int           n_checked = 0;
    int           n_errors = 0;
    int           status_seen [5] = '{default: 0};
    int           burst_left = 0;

    ordered_list_engine DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .position       (position),
        .value          (value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .item_value     (item_value),
        .found_position (found_position),
        .found          (found),
        .entry_count    (entry_count),
        .is_empty       (is_empty)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("** ordered_list_engine: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // list predictor: applies one command and returns the result word
    // ------------------------------------------------------------------------
    function automatic list_result_t apply_list_cmd(input logic [3:0] op,
                                                    input logic [6:0] pos,
                                                    input logic [31:0] val);
        list_result_t res;
        int first_hit;
        int last_hit;
        int at;
        int i;
        bit pos_ok;
        res.status         = STAT_OK;
        res.item_value     = '0;
        res.found_position = '0;
        res.found          = 1'b0;
        first_hit = 0;
        last_hit  = 0;
        for (i = 0; i < list_count; i++)
        begin
            if (list_words[i] == val)
            begin
                if (first_hit == 0)
                    first_hit = i + 1;
                last_hit = i + 1;
            end
        end
        pos_ok = (pos >= 1) && (int'(pos) <= list_count);

        case (op)
            CMD_APPEND:
            begin
                if (list_count >= LIST_DEPTH)
                    res.status = STAT_FULL;
                else
                begin
                    list_words[list_count] = val;
                    list_count++;
                    res.found_position = 7'(list_count);
                end
            end
            CMD_REMOVE_AT, CMD_REMOVE_VAL:
            begin
                at = (op == CMD_REMOVE_AT) ? int'(pos) : first_hit;
                if (list_count == 0)
                    res.status = STAT_EMPTY;
                else if (op == CMD_REMOVE_AT && !pos_ok)
                    res.status = STAT_RANGE;
                else if (op == CMD_REMOVE_VAL && first_hit == 0)
                    res.status = STAT_NOT_FOUND;
                else
                begin
                    res.item_value     = list_words[at - 1];
                    res.found_position = 7'(at);
                    res.found          = (op == CMD_REMOVE_VAL);
                    // close the gap
                    for (i = at - 1; i + 1 < list_count; i++)
                        list_words[i] = list_words[i + 1];
                    list_count--;
                end
            end
            CMD_CLEAR:
                list_count = 0;
            CMD_GET, CMD_REPLACE:
            begin
                if (list_count == 0)
                    res.status = STAT_EMPTY;
                else if (!pos_ok)
                    res.status = STAT_RANGE;
                else
                begin
                    res.found_position = pos;
                    if (op == CMD_GET)
                        res.item_value = list_words[pos - 1];
                    else
                        list_words[pos - 1] = val;
                end
            end
            CMD_FIRST, CMD_LAST, CMD_CONTAINS:
            begin
                if (list_count == 0)
                    res.status = STAT_EMPTY;
                else if (first_hit == 0)
                    res.status = STAT_NOT_FOUND;
                else
                begin
                    res.found          = 1'b1;
                    res.found_position = 7'((op == CMD_LAST) ? last_hit : first_hit);
                end
            end
            default:
                ;
        endcase

        res.entry_count = 7'(list_count);
        res.is_empty    = (list_count == 0);
        if (list_count > peak_count)
            peak_count = list_count;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (n_errors < MAX_REPORTS)
            $display("[%0t] word %0d: %s got 0x%0h expected 0x%0h",
                     $realtime, n_checked, what, got, want);
        n_errors++;
    endtask

    task automatic check_result();
        list_result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch("result with nothing pending, status", 32'(status), '0);
            return;
        end
        want = pending_results.pop_front();
        if (status !== want.status)
            report_mismatch("status", 32'(status), 32'(want.status));
        if (item_value !== want.item_value)
            report_mismatch("item_value", item_value, want.item_value);
        if (found_position !== want.found_position)
            report_mismatch("found_position", 32'(found_position),
                            32'(want.found_position));
        if (found !== want.found)
            report_mismatch("found", 32'(found), 32'(want.found));
        if (entry_count !== want.entry_count)
            report_mismatch("entry_count", 32'(entry_count), 32'(want.entry_count));
        if (is_empty !== want.is_empty)
            report_mismatch("is_empty", 32'(is_empty), 32'(want.is_empty));
        n_checked++;
    endtask

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            check_result();

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    // valid stays up after acceptance until the next falling edge, where the
    // next word or an idle cycle replaces it
    task automatic send_word(input logic [3:0] op, input logic [6:0] pos,
                             input logic [31:0] val);
        list_result_t res;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= op;
        position <= pos;
        value    <= val;
        do
            @(posedge clk);
        while (!in_ready);
        res = apply_list_cmd(op, pos, val);
        pending_results.push_back(res);
        status_seen[res.status]++;
        n_sent++;
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] corner_vals [6];
        int r;
        corner_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                        32'h1, 32'h5555_AAAA};
        r = $urandom_range(0, 99);
        if (list_count > 0 && r < 45)
            return list_words[$urandom_range(0, list_count - 1)];
        else if (r < 65)
            return corner_vals[$urandom_range(0, 5)];
        return $urandom();
    endfunction

    function automatic logic [6:0] pick_position();
        int r;
        r = $urandom_range(0, 99);
        if (list_count > 0 && r < 75)
            return 7'($urandom_range(1, list_count));
        else if (r < 82)
            return '0;
        else if (r < 92 && list_count < LIST_DEPTH)
            return 7'($urandom_range(list_count + 1, LIST_DEPTH));
        return 7'($urandom_range(0, 127));
    endfunction

    function automatic logic [3:0] pick_cmd();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return CMD_APPEND;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            burst_left = $urandom_range(10, 40);
            return CMD_APPEND;
        end
        if (r < 30) return CMD_APPEND;
        if (r < 40) return CMD_REMOVE_AT;
        if (r < 48) return CMD_REMOVE_VAL;
        if (r < 50) return CMD_CLEAR;
        if (r < 62) return CMD_GET;
        if (r < 70) return CMD_FIRST;
        if (r < 78) return CMD_LAST;
        if (r < 88) return CMD_REPLACE;
        if (r < 96) return CMD_CONTAINS;
        return 4'($urandom_range(CMD_CONTAINS + 1, CMD_UNUSED_MAX));
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_empty_list();
        send_word(CMD_REMOVE_AT, 7'd1, 32'h0);
        send_word(CMD_REMOVE_VAL, 7'd0, 32'h0);
        send_word(CMD_GET, 7'd1, 32'h0);
        send_word(CMD_FIRST, 7'd0, 32'hFFFF_FFFF);
        send_word(CMD_LAST, 7'd0, 32'h8000_0000);
        send_word(CMD_REPLACE, 7'd1, 32'h7FFF_FFFF);
        send_word(CMD_CONTAINS, 7'd0, 32'h0);
        send_word(CMD_CLEAR, 7'd0, 32'h0);
    endtask

    task automatic test_positions_and_search();
        send_word(CMD_APPEND, 7'd0, 32'h8000_0000);
        send_word(CMD_APPEND, 7'd0, 32'h7FFF_FFFF);
        send_word(CMD_APPEND, 7'd0, 32'h0);
        send_word(CMD_APPEND, 7'd0, 32'hFFFF_FFFF);
        send_word(CMD_APPEND, 7'd127, 32'h8000_0000);
        send_word(CMD_GET, 7'd0, 32'h0);
        send_word(CMD_GET, 7'd6, 32'h0);
        send_word(CMD_GET, 7'd127, 32'h0);
        send_word(CMD_GET, 7'd5, 32'h0);
        send_word(CMD_FIRST, 7'd0, 32'h8000_0000);
        send_word(CMD_LAST, 7'd0, 32'h8000_0000);
        send_word(CMD_CONTAINS, 7'd0, 32'h1234_5678);
        send_word(CMD_REMOVE_VAL, 7'd0, 32'hFFFF_FFFF);
        send_word(CMD_REMOVE_AT, 7'd1, 32'h0);
        send_word(CMD_REPLACE, 7'd2, 32'h5A5A_A5A5);
        send_word(CMD_REMOVE_AT, 7'd0, 32'h0);
        send_word(CMD_UNUSED_MAX, 7'd127, 32'hFFFF_FFFF);
        send_word(CMD_CLEAR, 7'd0, 32'h0);
    endtask

    // fill with random words, then push past capacity and poke the last slot
    task automatic test_fill_to_capacity();
        while (list_count < LIST_DEPTH)
            send_word(CMD_APPEND, 7'($urandom_range(0, 127)), pick_value());
        repeat (3)
            send_word(CMD_APPEND, '0, $urandom());
        send_word(CMD_GET, 7'(LIST_DEPTH), '0);
        send_word(CMD_GET, 7'(LIST_DEPTH + 1), '0);
        send_word(CMD_LAST, '0, list_words[0]);
        send_word(CMD_REMOVE_AT, 7'(LIST_DEPTH), '0);
        send_word(CMD_APPEND, '0, 32'h7FFF_FFFF);
    endtask

    task automatic test_random_commands(input int n_words);
        int k;
        logic [3:0] op;
        for (k = 0; k < n_words; k++)
        begin
            op = pick_cmd();
            send_word(op, pick_position(), pick_value());
            // hold the sender now and then until the result side is empty
            if (k % 100 == 99)
                wait_for_drain();
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 35;
        recv_idle_pct = 56;
        test_empty_list();
        test_positions_and_search();
        test_random_commands(300);

        send_idle_pct = 56;
        recv_idle_pct = 35;
        test_fill_to_capacity();
        test_random_commands(260);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_fill_to_capacity();
        test_random_commands(240);

        wait_for_drain();
        repeat (20) @(posedge clk);

        $display("%0d command words sent, %0d results checked, longest list %0d",
                 n_sent, n_checked, peak_count);
        $display("status mix: ok %0d, empty %0d, range %0d, not found %0d, full %0d",
                 status_seen[STAT_OK], status_seen[STAT_EMPTY], status_seen[STAT_RANGE],
                 status_seen[STAT_NOT_FOUND], status_seen[STAT_FULL]);
        if (n_errors == 0)
            $display("** ordered_list_engine: PASSED **");
        else
            $display("** ordered_list_engine: FAILED **");
        $finish;
    end

endmodule
